FILE: rtl/core/gjct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gjct_pkg: shared types and constants of the gesture jog / cubic core
// Fixed-point limits, gesture and opcode codes, and the request/response
// bundles between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package gjct_pkg;

  localparam int NUM_JOINTS = 5;
  localparam int NUM_MACROS = 3;

  // Opcodes of an input item
  localparam logic [1:0] OP_GESTURE = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Gesture codes
  localparam logic [2:0] G_UNKNOWN  = 3'd0;
  localparam logic [2:0] G_REST     = 3'd1;
  localparam logic [2:0] G_FIST     = 3'd2;
  localparam logic [2:0] G_SPREAD   = 3'd3;
  localparam logic [2:0] G_WAVE_IN  = 3'd4;
  localparam logic [2:0] G_WAVE_OUT = 3'd5;
  localparam logic [2:0] G_PINKY    = 3'd6;

  // Modes
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_JOG_A  = 3'd1;
  localparam logic [2:0] MODE_JOG_B  = 3'd2;
  localparam logic [2:0] MODE_RECORD = 3'd3;
  localparam logic [2:0] MODE_PLAY   = 3'd4;

  // Vibrate codes
  localparam logic [1:0] VIB_NONE  = 2'd0;
  localparam logic [1:0] VIB_MODE  = 2'd1;
  localparam logic [1:0] VIB_MACRO = 2'd2;

  // Configuration register indexes
  localparam logic REG_JOG_STEP    = 1'b0;
  localparam logic REG_UPDATE_RATE = 1'b1;

  localparam logic [16:0] JOG_STEP_RST    = 17'd655;
  localparam logic [9:0]  UPDATE_RATE_RST = 10'd10;

  // Q16.16 joint limits
  localparam logic signed [31:0] LIM_J1  = 32'sd124518;
  localparam logic signed [31:0] LIM_J2  = 32'sd114324;
  localparam logic signed [31:0] LIM_J34 = 32'sd102892;

  localparam logic [31:0] LOCKOUT_MS = 32'd1000;
  localparam logic [31:0] MS_PER_S   = 32'd1000;
  localparam logic [31:0] TF_MIN     = 32'h0002_0000;

  typedef enum logic {ALU_MUL = 1'b0, ALU_DIV = 1'b1} alu_op_t;

  typedef struct packed {
    logic               start;
    alu_op_t            op;
    logic signed [63:0] a;
    logic [31:0]        b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } alu_rsp_t;

  // Saturate a 64-bit signed value to int32
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gjct_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gjct_alu: shared multiply / divide unit
// Sign-magnitude, one bit per cycle. MUL gives (a*b)/65536 and DIV gives a/b,
// both truncated toward zero; b is an unsigned divisor or multiplier.
// ----------------------------------------------------------------------------
module gjct_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  gjct_pkg::alu_req_t  req,
  output gjct_pkg::alu_rsp_t  rsp
);

  localparam logic [6:0] MUL_STEPS = 7'd32;
  localparam logic [6:0] DIV_STEPS = 7'd64;

  logic               busy_r;
  logic               done_r;
  gjct_pkg::alu_op_t  op_r;
  logic               neg_r;
  logic [6:0]         cnt_r;
  logic [63:0]        acc_r;
  logic [63:0]        x_r;
  logic [31:0]        y_r;
  logic [31:0]        rem_r;
  logic signed [63:0] res_r;

  logic [63:0] mag_a;
  logic [32:0] sh;
  logic        ge;
  logic [63:0] mag_res;

  assign mag_a   = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign sh      = {rem_r, acc_r[63]};
  assign ge      = sh >= {1'b0, y_r};
  assign mag_res = (op_r == gjct_pkg::ALU_MUL) ? {16'b0, acc_r[63:16]} : acc_r;

  // Run one bit of the operation per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        neg_r  <= req.a[63];
        y_r    <= req.b;
        rem_r  <= '0;
        if (req.op == gjct_pkg::ALU_MUL) begin
          acc_r <= '0;
          x_r   <= mag_a;
          cnt_r <= MUL_STEPS;
        end else begin
          acc_r <= mag_a;
          x_r   <= '0;
          cnt_r <= DIV_STEPS;
        end
      end else if (busy_r) begin
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= neg_r ? -$signed(mag_res) : $signed(mag_res);
        end else begin
          cnt_r <= cnt_r - 7'd1;
          if (op_r == gjct_pkg::ALU_MUL) begin
            if (y_r[0]) acc_r <= acc_r + x_r;
            x_r <= {x_r[62:0], 1'b0};
            y_r <= {1'b0, y_r[31:1]};
          end else begin
            rem_r <= ge ? 32'(sh - {1'b0, y_r}) : sh[31:0];
            acc_r <= {acc_r[62:0], ge};
          end
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

FILE: rtl/core/gjct_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gjct_conv: Q16.16 to thousandths converter
// Multiplies by 1000 with shifts, truncates toward zero, saturates to int16.
// ----------------------------------------------------------------------------
module gjct_conv (
  input  logic signed [31:0] q,
  output logic signed [15:0] milli
);

  logic signed [41:0] qx;
  logic signed [41:0] p;
  logic signed [41:0] adj;
  logic signed [41:0] s;

  // 1000 = 1024 - 16 - 8
  assign qx  = 42'(q);
  assign p   = (qx <<< 10) - (qx <<< 4) - (qx <<< 3);
  assign adj = p + (p[41] ? 42'sd65535 : 42'sd0);
  assign s   = adj >>> 16;

  always_comb begin
    if (s > 42'sd32767) milli = 16'sh7FFF;
    else if (s < -42'sd32768) milli = 16'sh8000;
    else milli = s[15:0];
  end

endmodule
`default_nettype wire

FILE: rtl/core/gesture_jog_cubic_trajectory_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gesture_jog_cubic_trajectory_core: five-joint gesture arm commander
// Gesture, load and tick items drive jog, macro record and cubic playback
// in Q16.16; each tick emits one result per joint in thousandths.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | opcode, gesture, load, time
//  out_    | output    | out_valid/out_ready| joint, pos/vel/acc, mode, vibrate, last
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
//  One item at a time; in_ready is high only when the sequencer is idle.
//  The shared unit runs one divide or multiply at a time: a load issues two
//  divides, a play tick one divide and 25 multiplies, or 26 divides and 25
//  multiplies when it replans; other ticks use no shared-unit operations.
//  Results wait in an output register as long as out_ready is low.
//  Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gesture_jog_cubic_trajectory_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [2:0]         in_gesture_code,
  input  logic [2:0]         in_load_joint,
  input  logic signed [15:0] in_load_position,
  input  logic signed [15:0] in_load_velocity,
  input  logic [31:0]        in_time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_joint,
  output logic signed [15:0] out_position_out,
  output logic signed [15:0] out_velocity_out,
  output logic signed [15:0] out_acceleration_out,
  output logic [2:0]         out_mode_out,
  output logic [1:0]         out_vibrate,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [16:0]        cfg_wdata
);

  localparam int NJ = gjct_pkg::NUM_JOINTS;
  localparam logic [2:0] J_LAST = 3'(gjct_pkg::NUM_JOINTS - 1);
  localparam logic [2:0] J_ARM  = 3'd2;
  localparam logic [2:0] K_LAST = 3'd4;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_LDP  = 12'b0000_0000_0010,
    S_LDV  = 12'b0000_0000_0100,
    S_TICK = 12'b0000_0000_1000,
    S_TCHK = 12'b0000_0001_0000,
    S_GOAL = 12'b0000_0010_0000,
    S_TF   = 12'b0000_0100_0000,
    S_PLAN = 12'b0000_1000_0000,
    S_EVAL = 12'b0001_0000_0000,
    S_REC  = 12'b0010_0000_0000,
    S_EMIT = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] j_r, j_nxt;
  logic [2:0] k_r, k_nxt;
  logic       issued_r, issued_nxt;

  // Configuration and mode state
  logic [16:0] jog_step_r;
  logic [9:0]  rate_r;
  logic [2:0]  mode_r;
  logic [2:0]  gest_r;
  logic        locked_r;
  logic [31:0] mtime_r;
  logic [31:0] ptime_r;
  logic [31:0] dur_r;
  logic        loaded_r;
  logic [1:0]  vib_r;

  // Joint and plan storage
  logic signed [31:0] pos_r [NJ];
  logic signed [31:0] vel_r [NJ];
  logic signed [31:0] acc_r [NJ];
  logic signed [31:0] a0_r  [NJ];
  logic signed [31:0] a2_r  [NJ];
  logic signed [31:0] a3_r  [NJ];
  logic signed [31:0] mac_r [NJ * gjct_pkg::NUM_MACROS];

  // Item latch and work registers
  logic signed [15:0] ld_pos_r;
  logic signed [15:0] ld_vel_r;
  logic [31:0]        now_r;
  logic [31:0]        t_r;
  logic [31:0]        tf_r;
  logic [32:0]        maxd_r;
  logic signed [63:0] tmp_r;
  logic signed [31:0] e_a2t_r;
  logic signed [31:0] e_a3t_r;
  logic signed [31:0] e_a3tt_r;
  logic signed [31:0] e_p1_r;

  // Output register
  logic               out_valid_r;
  logic [2:0]         out_joint_r;
  logic signed [15:0] out_pos_r;
  logic signed [15:0] out_vel_r;
  logic signed [15:0] out_acc_r;
  logic [2:0]         out_mode_r;
  logic [1:0]         out_vib_r;
  logic               out_last_r;

  gjct_pkg::alu_req_t alu_req;
  gjct_pkg::alu_rsp_t alu_rsp;
  logic               alu_fire;

  gjct_alu u_alu (
    .clk (clk),
    .rst_n (rst_n),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Clamp a joint position to its limits
  function automatic logic signed [31:0] clamp_joint(input logic [2:0] j,
                                                     input logic signed [31:0] v);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] r;
    lo = 32'sh8000_0000;
    hi = 32'sh7FFF_FFFF;
    case (j)
      3'd1: begin lo = -gjct_pkg::LIM_J1;  hi = gjct_pkg::LIM_J1;  end
      3'd2: begin lo = -gjct_pkg::LIM_J2;  hi = gjct_pkg::LIM_J2;  end
      3'd3: begin lo = -gjct_pkg::LIM_J34; hi = 32'sd0;            end
      3'd4: begin lo = 32'sd0;             hi = gjct_pkg::LIM_J34; end
      default: ;
    endcase
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

  // Macro row base for gestures spread, wave in and wave out
  function automatic logic [3:0] mac_base(input logic [2:0] g);
    logic [3:0] b;
    case (g)
      gjct_pkg::G_WAVE_IN:  b = 4'(NJ);
      gjct_pkg::G_WAVE_OUT: b = 4'(2 * NJ);
      default:              b = 4'd0;
    endcase
    return b;
  endfunction

  // Derived values
  logic               act;
  logic               is_macro_g;
  logic               lock_eff;
  logic               rec_go;
  logic [3:0]         mac_idx;
  logic signed [31:0] goal_j;
  logic signed [63:0] d64;
  logic signed [63:0] d3;
  logic [32:0]        absd;
  logic [34:0]        tf3;
  logic [31:0]        tf_new;
  logic [31:0]        tdiff;
  logic [31:0]        tcap;
  logic [26:0]        jv_mag;
  logic signed [31:0] jv_up;
  logic signed [31:0] jv_dn;
  logic signed [31:0] pos_clamped;
  logic signed [15:0] cv_pos;
  logic signed [15:0] cv_vel;
  logic signed [15:0] cv_acc;
  logic signed [31:0] mres;
  logic [2:0]         mode_inc;

  assign act        = (gest_r != gjct_pkg::G_UNKNOWN) && (gest_r != gjct_pkg::G_PINKY);
  assign is_macro_g = (gest_r == gjct_pkg::G_SPREAD) || (gest_r == gjct_pkg::G_WAVE_IN) ||
                      (gest_r == gjct_pkg::G_WAVE_OUT);
  assign lock_eff   = ((now_r - mtime_r) > gjct_pkg::LOCKOUT_MS) ? 1'b0 : locked_r;
  assign rec_go     = is_macro_g && !lock_eff;
  assign mac_idx    = mac_base(gest_r) + {1'b0, j_r};

  always_comb begin
    if (gest_r == gjct_pkg::G_FIST) goal_j = 32'sd0;
    else if (is_macro_g) goal_j = mac_r[mac_idx];
    else goal_j = pos_r[j_r];
  end

  assign d64    = 64'(goal_j) - 64'(pos_r[j_r]);
  assign d3     = (d64 <<< 1) + d64;
  assign absd   = d64[63] ? 33'(-d64) : 33'(d64);
  assign tf3    = {2'b0, maxd_r} + {1'b0, maxd_r, 1'b0};
  assign tf_new = (tf3 < 35'(gjct_pkg::TF_MIN)) ? gjct_pkg::TF_MIN :
                  ((tf3[34:32] != 3'd0) ? 32'hFFFF_FFFF : tf3[31:0]);
  assign tdiff  = now_r - ptime_r;
  assign tcap   = (alu_rsp.res[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_rsp.res[31:0];
  assign jv_mag = 27'(jog_step_r) * 27'(rate_r);
  assign jv_up  = $signed({5'b0, jv_mag});
  assign jv_dn  = -jv_up;
  assign mres   = gjct_pkg::sat32(alu_rsp.res);
  assign mode_inc = (mode_r >= gjct_pkg::MODE_PLAY) ? gjct_pkg::MODE_OFF : mode_r + 3'd1;
  assign alu_fire = issued_r && alu_rsp.done;
  assign pos_clamped = clamp_joint(j_r, pos_r[j_r]);

  gjct_conv u_conv_pos (.q(pos_clamped), .milli(cv_pos));
  gjct_conv u_conv_vel (.q(vel_r[j_r]),  .milli(cv_vel));
  gjct_conv u_conv_acc (.q(acc_r[j_r]),  .milli(cv_acc));

  // Sequencer and shared unit operands
  always_comb begin
    state_nxt   = state_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    issued_nxt  = issued_r;
    alu_req.start = 1'b0;
    alu_req.op    = gjct_pkg::ALU_DIV;
    alu_req.a     = '0;
    alu_req.b     = gjct_pkg::MS_PER_S;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          j_nxt = in_load_joint;
          case (in_opcode)
            gjct_pkg::OP_GESTURE: if (in_gesture_code == gjct_pkg::G_PINKY) state_nxt = S_OUT;
            gjct_pkg::OP_LOAD:
              if (!loaded_r && (in_load_joint <= J_LAST)) state_nxt = S_LDP;
            gjct_pkg::OP_TICK:    state_nxt = S_TICK;
            default: ;
          endcase
        end
      end
      S_LDP: begin
        alu_req.a = 64'(ld_pos_r) <<< 16;
        if (alu_fire) state_nxt = S_LDV;
      end
      S_LDV: begin
        alu_req.a = 64'(ld_vel_r) <<< 16;
        if (alu_fire) state_nxt = S_IDLE;
      end
      S_TICK: begin
        j_nxt = 3'd0;
        k_nxt = 3'd0;
        if (act && mode_r == gjct_pkg::MODE_PLAY) state_nxt = S_TCHK;
        else if (act && mode_r == gjct_pkg::MODE_RECORD && rec_go) state_nxt = S_REC;
        else state_nxt = S_EMIT;
      end
      S_TCHK: begin
        alu_req.a = $signed({16'b0, tdiff, 16'b0});
        if (alu_fire) state_nxt = (tcap >= dur_r) ? S_GOAL : S_EVAL;
      end
      S_GOAL: begin
        if (j_r == J_ARM) begin
          state_nxt = S_TF;
          j_nxt = 3'd0;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      S_TF: begin
        j_nxt = 3'd0;
        k_nxt = 3'd0;
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        alu_req.b = tf_r;
        case (k_r)
          3'd0:    alu_req.a = d3 <<< 16;
          3'd2:    alu_req.a = -(d64 <<< 17);
          default: alu_req.a = tmp_r <<< 16;
        endcase
        if (alu_fire) begin
          if (k_r == K_LAST) begin
            k_nxt = 3'd0;
            if (j_r == J_LAST) begin
              j_nxt = 3'd0;
              state_nxt = S_EVAL;
            end else begin
              j_nxt = j_r + 3'd1;
            end
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      S_EVAL: begin
        alu_req.op = gjct_pkg::ALU_MUL;
        alu_req.b  = t_r;
        case (k_r)
          3'd0:    alu_req.a = 64'(a2_r[j_r]);
          3'd1:    alu_req.a = 64'(a3_r[j_r]);
          3'd2:    alu_req.a = 64'(e_a3t_r);
          3'd3:    alu_req.a = 64'(e_a2t_r);
          default: alu_req.a = 64'(e_a3tt_r);
        endcase
        if (alu_fire) begin
          if (k_r == K_LAST) begin
            k_nxt = 3'd0;
            if (j_r == J_LAST) begin
              j_nxt = 3'd0;
              state_nxt = S_EMIT;
            end else begin
              j_nxt = j_r + 3'd1;
            end
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      S_REC: begin
        if (j_r == J_LAST) begin
          j_nxt = 3'd0;
          state_nxt = S_EMIT;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      S_EMIT: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt = j_r + 3'd1;
            state_nxt = S_EMIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Issue one operation at a time in the compute states, drop the flag when it returns
    if ((state_r == S_LDP) || (state_r == S_LDV) || (state_r == S_TCHK) ||
        (state_r == S_PLAN) || (state_r == S_EVAL)) begin
      alu_req.start = !issued_r;
      if (!issued_r) issued_nxt = 1'b1;
      else if (alu_rsp.done) issued_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      j_r      <= 3'd0;
      k_r      <= 3'd0;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      issued_r <= issued_nxt;
    end
  end

  // Datapath and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jog_step_r  <= gjct_pkg::JOG_STEP_RST;
      rate_r      <= gjct_pkg::UPDATE_RATE_RST;
      mode_r      <= gjct_pkg::MODE_JOG_A;
      gest_r      <= gjct_pkg::G_UNKNOWN;
      locked_r    <= 1'b0;
      mtime_r     <= '0;
      ptime_r     <= '0;
      dur_r       <= '0;
      loaded_r    <= 1'b0;
      vib_r       <= gjct_pkg::VIB_NONE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NJ; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        acc_r[i] <= '0;
        a0_r[i]  <= '0;
        a2_r[i]  <= '0;
        a3_r[i]  <= '0;
      end
      for (int i = 0; i < NJ * gjct_pkg::NUM_MACROS; i++) mac_r[i] <= '0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          gjct_pkg::REG_JOG_STEP:    jog_step_r <= cfg_wdata;
          gjct_pkg::REG_UPDATE_RATE: rate_r     <= cfg_wdata[9:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ld_pos_r <= in_load_position;
            ld_vel_r <= in_load_velocity;
            now_r    <= in_time_ms;
            if (in_opcode == gjct_pkg::OP_GESTURE && in_gesture_code != 3'd7) begin
              gest_r <= in_gesture_code;
              if (in_gesture_code == gjct_pkg::G_PINKY) begin
                mode_r      <= mode_inc;
                out_valid_r <= 1'b1;
                out_joint_r <= 3'd0;
                out_pos_r   <= '0;
                out_vel_r   <= '0;
                out_acc_r   <= '0;
                out_mode_r  <= mode_inc;
                out_vib_r   <= gjct_pkg::VIB_MODE;
                out_last_r  <= 1'b1;
              end
            end
          end
        end
        S_LDP: if (alu_fire) pos_r[j_r] <= alu_rsp.res[31:0];
        S_LDV: if (alu_fire) vel_r[j_r] <= alu_rsp.res[31:0];
        S_TICK: begin
          loaded_r <= 1'b1;
          vib_r    <= gjct_pkg::VIB_NONE;
          maxd_r   <= '0;
          if (act) begin
            if ((mode_r == gjct_pkg::MODE_JOG_A || mode_r == gjct_pkg::MODE_JOG_B) &&
                gest_r == gjct_pkg::G_REST) begin
              for (int i = 0; i < NJ; i++) vel_r[i] <= '0;
            end else if (mode_r == gjct_pkg::MODE_JOG_A) begin
              case (gest_r)
                gjct_pkg::G_FIST: begin
                  pos_r[1] <= gjct_pkg::sat32(64'(pos_r[1]) + 64'(jog_step_r));
                  vel_r[1] <= jv_up;
                end
                gjct_pkg::G_SPREAD: begin
                  pos_r[1] <= gjct_pkg::sat32(64'(pos_r[1]) - 64'(jog_step_r));
                  vel_r[1] <= jv_dn;
                end
                gjct_pkg::G_WAVE_IN: begin
                  pos_r[0] <= gjct_pkg::sat32(64'(pos_r[0]) + 64'(jog_step_r));
                  vel_r[0] <= jv_up;
                end
                gjct_pkg::G_WAVE_OUT: begin
                  pos_r[0] <= gjct_pkg::sat32(64'(pos_r[0]) - 64'(jog_step_r));
                  vel_r[0] <= jv_dn;
                end
                default: ;
              endcase
            end else if (mode_r == gjct_pkg::MODE_JOG_B) begin
              case (gest_r)
                gjct_pkg::G_FIST: begin
                  pos_r[3] <= gjct_pkg::sat32(64'(pos_r[3]) + 64'(jog_step_r));
                  vel_r[3] <= jv_up;
                  pos_r[4] <= gjct_pkg::sat32(64'(pos_r[4]) - 64'(jog_step_r));
                  vel_r[4] <= jv_dn;
                end
                gjct_pkg::G_SPREAD: begin
                  pos_r[3] <= gjct_pkg::sat32(64'(pos_r[3]) - 64'(jog_step_r));
                  vel_r[3] <= jv_dn;
                  pos_r[4] <= gjct_pkg::sat32(64'(pos_r[4]) + 64'(jog_step_r));
                  vel_r[4] <= jv_up;
                end
                gjct_pkg::G_WAVE_IN: begin
                  pos_r[2] <= gjct_pkg::sat32(64'(pos_r[2]) + 64'(jog_step_r));
                  vel_r[2] <= jv_up;
                end
                gjct_pkg::G_WAVE_OUT: begin
                  pos_r[2] <= gjct_pkg::sat32(64'(pos_r[2]) - 64'(jog_step_r));
                  vel_r[2] <= jv_dn;
                end
                default: ;
              endcase
            end else if (mode_r == gjct_pkg::MODE_RECORD) begin
              locked_r <= lock_eff;
              if (rec_go) begin
                locked_r <= 1'b1;
                mtime_r  <= now_r;
                vib_r    <= gjct_pkg::VIB_MACRO;
              end
            end
          end
        end
        S_TCHK: if (alu_fire) t_r <= tcap;
        S_GOAL: if (absd > maxd_r) maxd_r <= absd;
        S_TF: begin
          dur_r <= tf_new;
          tf_r  <= tf_new;
          if (gest_r == gjct_pkg::G_FIST || is_macro_g) begin
            ptime_r <= now_r;
            t_r     <= '0;
          end
        end
        S_PLAN: begin
          if (alu_fire) begin
            case (k_r)
              3'd1: a2_r[j_r] <= mres;
              3'd4: begin
                a3_r[j_r] <= mres;
                a0_r[j_r] <= pos_r[j_r];
              end
              default: tmp_r <= alu_rsp.res;
            endcase
          end
        end
        S_EVAL: begin
          if (alu_fire) begin
            case (k_r)
              3'd0: e_a2t_r  <= mres;
              3'd1: e_a3t_r  <= mres;
              3'd2: e_a3tt_r <= mres;
              3'd3: e_p1_r   <= mres;
              default: begin
                pos_r[j_r] <= gjct_pkg::sat32(64'(a0_r[j_r]) + 64'(e_p1_r) + 64'(mres));
                vel_r[j_r] <= gjct_pkg::sat32((64'(e_a2t_r) <<< 1) + (64'(e_a3tt_r) <<< 1) +
                                              64'(e_a3tt_r));
                acc_r[j_r] <= gjct_pkg::sat32((64'(a2_r[j_r]) <<< 1) + (64'(e_a3t_r) <<< 2) +
                                              (64'(e_a3t_r) <<< 1));
              end
            endcase
          end
        end
        S_REC: mac_r[mac_idx] <= pos_r[j_r];
        S_EMIT: begin
          pos_r[j_r]  <= pos_clamped;
          out_valid_r <= 1'b1;
          out_joint_r <= j_r;
          out_pos_r   <= cv_pos;
          out_vel_r   <= cv_vel;
          out_acc_r   <= cv_acc;
          out_mode_r  <= mode_r;
          out_vib_r   <= vib_r;
          out_last_r  <= (j_r == J_LAST);
        end
        S_OUT: if (out_ready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_joint            = out_joint_r;
  assign out_position_out     = out_pos_r;
  assign out_velocity_out     = out_vel_r;
  assign out_acceleration_out = out_acc_r;
  assign out_mode_out         = out_mode_r;
  assign out_vibrate          = out_vib_r;
  assign out_last             = out_last_r;

  // Never take an item while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");

  // The final result of an item frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready) else $error("no return to idle");

  // Mode stays within its range
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= gjct_pkg::MODE_PLAY) else $error("mode out of range");

  // Shared unit start is never held high in back-to-back cycles
  a_alu_once: assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |=> !alu_req.start) else $error("double start");

endmodule
`default_nettype wire
